[rtl/hbc_pkg.sv]
// shared types and constants for the high-pass biquad cascade with noise gate
// no dependencies; imported by every module of the block
`default_nettype none

package hbc_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS   = 24;
  localparam int COEFF_BITS    = 21;
  localparam int COEFF_REGS    = 4;
  localparam int CREG_W        = 2;
  localparam int THRESH_BITS   = 24;
  localparam int CFG_DATA_BITS = 3 * COEFF_BITS;
  localparam int CFG_IDX_BITS  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF1  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF2  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF3  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF4  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 3'd5;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B0,
    ST_ROUND,
    ST_MUL_A1,
    ST_MUL_A2,
    ST_FINISH
  } state_e;

  // per-cycle datapath controls from the sequencer
  typedef struct packed {
    logic load;
    logic mul_b0;
    logic mul_a1;
    logic mul_a2;
    logic upd_y;
    logic upd_z1;
    logic upd_z2;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          first_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          gated;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/hbc_seq.sv]
// sequencer: walks each section through multiply and add steps
// depends on hbc_pkg
`default_nettype none

module hbc_seq #(
  parameter int SECTIONS = 4,
  parameter int SEC_W    = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire                  en_i,
  input  wire                  out_free_i,
  output hbc_pkg::ctrl_t       ctrl_o,
  output logic [SEC_W-1:0]     sec_o
);
  import hbc_pkg::*;

  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTIONS - 1);

  state_e            state_q, state_d;
  logic [SEC_W-1:0]  sec_q, sec_d;

  // next state
  always_comb begin
    state_d = state_q;
    sec_d   = sec_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sec_d   = '0;
          state_d = en_i ? ST_MUL_B0 : ST_FINISH;
        end
      end
      ST_MUL_B0: state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_MUL_A1;
      ST_MUL_A1: state_d = ST_MUL_A2;
      ST_MUL_A2: begin
        if (sec_q == LAST_SEC) begin
          state_d = ST_FINISH;
        end else begin
          sec_d   = sec_q + 1'b1;
          state_d = ST_MUL_B0;
        end
      end
      ST_FINISH: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_MUL_B0: begin
        ctrl_o.mul_b0 = 1'b1;
        // finish the previous section's second delay
        ctrl_o.upd_z2 = (sec_q != '0);
      end
      ST_ROUND:  ctrl_o.upd_y  = 1'b1;
      ST_MUL_A1: ctrl_o.mul_a1 = 1'b1;
      ST_MUL_A2: begin
        ctrl_o.mul_a2 = 1'b1;
        ctrl_o.upd_z1 = 1'b1;
      end
      ST_FINISH: begin
        ctrl_o.out_load = out_free_i;
        ctrl_o.upd_z2   = out_free_i && en_i;
      end
      default: ctrl_o = '0;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
    end
  end

  assign sec_o = sec_q;

  // section counter stays inside the cascade
  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q <= LAST_SEC)
    else $error("section index out of range");

  // an enabled item starts at the first section
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && en_i) |=> (state_q == ST_MUL_B0 && sec_q == '0))
    else $error("enabled item did not start at first section");

  // a disabled item goes straight to the output step
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !en_i) |=> (state_q == ST_FINISH))
    else $error("disabled item did not bypass the cascade");

  // last section ends the cascade
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_A2 && sec_q == LAST_SEC) |=> (state_q == ST_FINISH))
    else $error("cascade did not finish after last section");

endmodule

`default_nettype wire

[rtl/hbc_dp.sv]
// datapath: shared multiplier, shared three-input adder, delay words and gate
// depends on hbc_pkg; controlled by hbc_seq
`default_nettype none

module hbc_dp #(
  parameter int SECTIONS        = 4,
  parameter int COEFF_FRAC_BITS = 18,
  parameter int SEC_W           = 2
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  hbc_pkg::ctrl_t                      ctrl_i,
  input  wire [SEC_W-1:0]                     sec_i,
  input  wire                                 en_i,
  input  wire [hbc_pkg::CFG_DATA_BITS-1:0]    coeffs_i,
  input  wire [hbc_pkg::THRESH_BITS-1:0]      thresh_i,
  input  hbc_pkg::in_item_t                   in_item_i,
  output hbc_pkg::out_item_t                  result_o
);
  import hbc_pkg::*;

  localparam int DELAY_BITS = SAMPLE_BITS + COEFF_FRAC_BITS + 6;
  localparam int PROD_W     = SAMPLE_BITS + COEFF_BITS;
  localparam int WIDE_W     = ((PROD_W > DELAY_BITS) ? PROD_W : DELAY_BITS) + 3;

  localparam logic signed [WIDE_W-1:0] RND =
    {{(WIDE_W-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [DELAY_BITS-1:0]  Z_MAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
  localparam logic signed [DELAY_BITS-1:0]  Z_MIN = {1'b1, {(DELAY_BITS-1){1'b0}}};

  logic signed [COEFF_BITS-1:0]  b0, a1, a2, coef_op;
  logic signed [SAMPLE_BITS-1:0] x_q, y_sat;
  logic signed [PROD_W-1:0]      prod_d, prod_q, bx_q;
  logic signed [DELAY_BITS-1:0]  z1_q [SECTIONS];
  logic signed [DELAY_BITS-1:0]  z2_q [SECTIONS];
  logic signed [DELAY_BITS-1:0]  z_sat;
  logic [SEC_W-1:0]              zi_q;
  logic signed [WIDE_W-1:0]      op_a, op_b, op_c, sum, shifted;
  logic                          y_ovf, z_ovf, mul_en, gate_hit;
  logic [SAMPLE_BITS:0]          x_ext, mag;

  // coefficient fields of the selected section
  assign b0 = coeffs_i[COEFF_BITS-1:0];
  assign a1 = coeffs_i[2*COEFF_BITS-1:COEFF_BITS];
  assign a2 = coeffs_i[3*COEFF_BITS-1:2*COEFF_BITS];

  // shared multiplier
  assign coef_op = ctrl_i.mul_b0 ? b0 : (ctrl_i.mul_a1 ? a1 : a2);
  assign mul_en  = ctrl_i.mul_b0 || ctrl_i.mul_a1 || ctrl_i.mul_a2;
  assign prod_d  = coef_op * x_q;

  // shared adder operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = '0;
    if (ctrl_i.upd_y) begin
      op_a = WIDE_W'(prod_q);
      op_b = WIDE_W'(z1_q[sec_i]);
      op_c = RND;
    end else if (ctrl_i.upd_z1) begin
      op_a = -(WIDE_W'(bx_q) <<< 1);
      op_b = -WIDE_W'(prod_q);
      op_c = WIDE_W'(z2_q[sec_i]);
    end else begin
      op_a = WIDE_W'(bx_q);
      op_b = -WIDE_W'(prod_q);
    end
  end

  assign sum     = op_a + op_b + op_c;
  assign shifted = sum >>> COEFF_FRAC_BITS;

  // section output saturation
  assign y_ovf = !((&shifted[WIDE_W-1:SAMPLE_BITS-1]) || (~|shifted[WIDE_W-1:SAMPLE_BITS-1]));
  assign y_sat = y_ovf ? (shifted[WIDE_W-1] ? Y_MIN : Y_MAX) : shifted[SAMPLE_BITS-1:0];

  // delay word saturation
  assign z_ovf = !((&sum[WIDE_W-1:DELAY_BITS-1]) || (~|sum[WIDE_W-1:DELAY_BITS-1]));
  assign z_sat = z_ovf ? (sum[WIDE_W-1] ? Z_MIN : Z_MAX) : sum[DELAY_BITS-1:0];

  // working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= in_item_i.sample_in;
    end else if (ctrl_i.upd_y) begin
      x_q <= y_sat;
    end
    if (mul_en)        prod_q <= prod_d;
    if (ctrl_i.upd_y)  bx_q   <= prod_q;
    if (ctrl_i.upd_z1) zi_q   <= sec_i;
  end

  // delay words, cleared at reset and at the start of a block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q <= '{default: '0};
      z2_q <= '{default: '0};
    end else if (ctrl_i.load && in_item_i.first_of_block) begin
      z1_q <= '{default: '0};
      z2_q <= '{default: '0};
    end else begin
      if (ctrl_i.upd_z1) z1_q[sec_i] <= z_sat;
      if (ctrl_i.upd_z2) z2_q[zi_q]  <= z_sat;
    end
  end

  // noise gate on the final sample
  assign x_ext    = {x_q[SAMPLE_BITS-1], x_q};
  assign mag      = x_q[SAMPLE_BITS-1] ? -x_ext : x_ext;
  assign gate_hit = en_i && (mag < (SAMPLE_BITS + 1)'(thresh_i));

  assign result_o.sample_out = gate_hit ? '0 : x_q;
  assign result_o.gated      = gate_hit;

endmodule

`default_nettype wire

[rtl/highpass_biquad_cascade_with_gate.sv]
// top level: configuration registers, output register, sequencer and datapath
// depends on hbc_pkg, hbc_seq and hbc_dp
//
// Usage: one signed 24-bit sample enters per item on the in_valid_i/in_ready_o
// channel, together with a first-of-block flag that clears all section delays.
// Each item gives exactly one result on out_valid_o/out_ready_i: the sample after
// SECTIONS high-pass biquads and the noise gate, or the sample unchanged when the
// filter is disabled. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i while no item is in flight.
// Steps: the shared multiplier and adder take each section in order through
// multiply by b0, round, multiply by a1 and multiply by a2; a disabled item skips
// the sections. The block takes no new item until the current result has been
// loaded into the output register.
// Reset clears the configuration registers, the delay words and the sequencer.
// A finished result waits in the output register; while the receiver stalls the
// block holds the next finished result and takes no new item until it is sent.
`default_nettype none

module highpass_biquad_cascade_with_gate #(
  parameter int SECTIONS        = 4,
  parameter int COEFF_FRAC_BITS = 18
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  hbc_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output hbc_pkg::out_item_t                  out_item_o,
  input  wire                                 cfg_we_i,
  input  wire [hbc_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  wire [hbc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i
);
  import hbc_pkg::*;

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  logic                     en_q;
  logic [CFG_DATA_BITS-1:0] coef_q [COEFF_REGS];
  logic [THRESH_BITS-1:0]   thresh_q;
  ctrl_t                    ctrl;
  logic [SEC_W-1:0]         sec;
  logic                     out_free;
  logic                     out_valid_q;
  out_item_t                out_item_q, result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      coef_q   <= '{default: '0};
      thresh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE: en_q <= cfg_wdata_i[0];
        REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4: begin
          coef_q[CREG_W'(cfg_idx_i - REG_COEF1)] <= cfg_wdata_i;
        end
        REG_THRESH: thresh_q <= cfg_wdata_i[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  hbc_seq #(
    .SECTIONS (SECTIONS),
    .SEC_W    (SEC_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .en_i       (en_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .sec_o      (sec)
  );

  hbc_dp #(
    .SECTIONS        (SECTIONS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
    .SEC_W           (SEC_W)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sec_i     (sec),
    .en_i      (en_q),
    .coeffs_i  (coef_q[CREG_W'(sec)]),
    .thresh_i  (thresh_q),
    .in_item_i (in_item_i),
    .result_o  (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a result is only loaded when the output slot is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output item overwritten before it was taken");

  // the block never takes an item while a load of the previous result is pending
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> !in_ready_o)
    else $error("input accepted while a result was being loaded");

  // a loaded result is offered on the next cycle
  a_offer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |=> out_valid_o)
    else $error("loaded result not offered");

endmodule

`default_nettype wire

[bench/hbc_checker.sv]
// checker for the high-pass biquad cascade with noise gate: watches the item and config ports,
// predicts each result bit-exactly and compares it with what the block sends
// depends on hbc_pkg
module hbc_checker #(
  parameter int SECTIONS        = 4,
  parameter int COEFF_FRAC_BITS = 18
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  input  wire                               in_ready_i,
  input  hbc_pkg::in_item_t                 in_item_i,
  input  wire                               out_valid_i,
  input  wire                               out_ready_i,
  input  hbc_pkg::out_item_t                out_item_i,
  input  wire                               cfg_we_i,
  input  wire [hbc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire [hbc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  localparam int DELAY_BITS = hbc_pkg::SAMPLE_BITS + COEFF_FRAC_BITS + 6;
  localparam int CREG_W     = hbc_pkg::CREG_W;

  // shadow copy of the configuration registers
  logic                               enable_q;
  logic [hbc_pkg::CFG_DATA_BITS-1:0]  coeff_q [hbc_pkg::COEFF_REGS];
  logic [hbc_pkg::THRESH_BITS-1:0]    thresh_q;

  // shadow copy of the section delay words
  logic signed [DELAY_BITS-1:0]       z1_q [SECTIONS];
  logic signed [DELAY_BITS-1:0]       z2_q [SECTIONS];

  // filtered samples still owed by the block, oldest first
  hbc_pkg::out_item_t                 filtered_q [$];
  hbc_pkg::out_item_t                 owed;
  hbc_pkg::out_item_t                 fresh;
  int                                 errors;

  // saturate to a signed width
  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // signed 21-bit coefficient number pos out of a packed register
  function automatic longint coeff_field(input logic [hbc_pkg::CFG_DATA_BITS-1:0] c,
                                         input int pos);
    logic signed [hbc_pkg::COEFF_BITS-1:0] f;
    f = c[pos * hbc_pkg::COEFF_BITS +: hbc_pkg::COEFF_BITS];
    return longint'(f);
  endfunction

  // run one sample through the cascade and gate, updating the delays
  task automatic filter_sample(input hbc_pkg::in_item_t it, output hbc_pkg::out_item_t res);
    logic signed [hbc_pkg::SAMPLE_BITS-1:0] s;
    logic [hbc_pkg::CFG_DATA_BITS-1:0]      c;
    longint x, b0, a1, a2, bx, acc, y, mag, th;
    int i;
    s = it.sample_in;
    x = longint'(s);
    res.gated = 1'b0;
    if (it.first_of_block) begin
      for (i = 0; i < SECTIONS; i++) begin
        z1_q[i] = '0;
        z2_q[i] = '0;
      end
    end
    if (enable_q) begin
      for (i = 0; i < SECTIONS; i++) begin
        c   = coeff_q[i % hbc_pkg::COEFF_REGS];
        b0  = coeff_field(c, 0);
        a1  = coeff_field(c, 1);
        a2  = coeff_field(c, 2);
        bx  = b0 * x;
        // round half up, then saturate the section output
        acc = bx + z1_q[i] + (longint'(1) <<< (COEFF_FRAC_BITS - 1));
        y   = clamp(acc >>> COEFF_FRAC_BITS, hbc_pkg::SAMPLE_BITS);
        // numerator fixed to b0, -2*b0, b0
        z1_q[i] = DELAY_BITS'(clamp(-2 * bx - a1 * y + z2_q[i], DELAY_BITS));
        z2_q[i] = DELAY_BITS'(clamp(bx - a2 * y, DELAY_BITS));
        x = y;
      end
      // noise gate on the magnitude
      mag = (x < 0) ? -x : x;
      th  = longint'(thresh_q);
      if (mag < th) begin
        x = 0;
        res.gated = 1'b1;
      end
    end
    res.sample_out = x[hbc_pkg::SAMPLE_BITS-1:0];
  endtask

  // watch all three ports at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q = 1'b0;
      thresh_q = '0;
      for (int i = 0; i < hbc_pkg::COEFF_REGS; i++) coeff_q[i] = '0;
      for (int i = 0; i < SECTIONS; i++) begin
        z1_q[i] = '0;
        z2_q[i] = '0;
      end
      filtered_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result side: compare with the oldest owed item
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected item: sample_out %0d gated %0b",
                 out_item_i.sample_out, out_item_i.gated);
          errors++;
        end else begin
          owed = filtered_q.pop_front();
          if (out_item_i.sample_out !== owed.sample_out) begin
            $error("sample_out: expected %0d, actual %0d",
                   owed.sample_out, out_item_i.sample_out);
            errors++;
          end
          if (out_item_i.gated !== owed.gated) begin
            $error("gated: expected %0b, actual %0b", owed.gated, out_item_i.gated);
            errors++;
          end
        end
      end
      // sample side: predict the result of each accepted item
      if (in_valid_i && in_ready_i) begin
        filter_sample(in_item_i, fresh);
        filtered_q.push_back(fresh);
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hbc_pkg::REG_ENABLE: enable_q = cfg_wdata_i[0];
          hbc_pkg::REG_COEF1, hbc_pkg::REG_COEF2,
          hbc_pkg::REG_COEF3, hbc_pkg::REG_COEF4: begin
            coeff_q[CREG_W'(cfg_idx_i - hbc_pkg::REG_COEF1)] = cfg_wdata_i;
          end
          hbc_pkg::REG_THRESH: thresh_q = cfg_wdata_i[hbc_pkg::THRESH_BITS-1:0];
          default: ;
        endcase
      end
      fail_count_o <= errors;
      pending_o    <= filtered_q.size();
    end
  end

endmodule

[bench/tb.sv]
// testbench top for the high-pass biquad cascade with noise gate: clock, reset, config
// phases, directed and random samples with random idling on both sides, final verdict
// depends on hbc_pkg, highpass_biquad_cascade_with_gate and hbc_checker
module tb;
  import hbc_pkg::*;

  // indexes past the last register, which the block ignores
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = 24'h7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = 24'h800000;
  localparam logic [COEFF_BITS-1:0]         C_MAX    = 21'h0FFFFF;
  localparam logic [COEFF_BITS-1:0]         C_MIN    = 21'h100000;
  localparam logic [CFG_DATA_BITS-1:0]      ALL_ONES = '1;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  in_item_t                  in_item;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_item;
  logic                      cfg_we;
  logic [CFG_IDX_BITS-1:0]   cfg_idx;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;
  int                        fail_count;
  int                        pending;
  int                        ready_hold = 0;
  int                        ready_pick;

  // register writes waiting to go out
  logic [CFG_IDX_BITS-1:0]   write_idx_q  [$];
  logic [CFG_DATA_BITS-1:0]  write_data_q [$];

  highpass_biquad_cascade_with_gate #(
    .SECTIONS        (4),
    .COEFF_FRAC_BITS (18)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  hbc_checker #(
    .SECTIONS        (4),
    .COEFF_FRAC_BITS (18)
  ) filter_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: ready in runs, mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 19);
      if (ready_pick < 10) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 19);
      end else if (ready_pick < 17) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else if (ready_pick < 19) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(50, 150);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(20, 60);
      end
    end
  end

  function automatic logic [CFG_DATA_BITS-1:0] pack_coeffs(input logic [COEFF_BITS-1:0] b0,
                                                           input logic [COEFF_BITS-1:0] a1,
                                                           input logic [COEFF_BITS-1:0] a2);
    return {a2, a1, b0};
  endfunction

  // real coefficient to Q3.18, rounded to nearest
  function automatic logic [COEFF_BITS-1:0] to_q18(input real v);
    int q;
    q = $rtoi(v * 262144.0 + ((v < 0.0) ? -0.5 : 0.5));
    return q[COEFF_BITS-1:0];
  endfunction

  // one high-pass section for cutoff fc (fraction of the sample rate) and quality q
  function automatic logic [CFG_DATA_BITS-1:0] hp_section(input real fc, input real q);
    real w0, cs, al, a0;
    w0 = 2.0 * 3.14159265358979 * fc;
    cs = $cos(w0);
    al = $sin(w0) / (2.0 * q);
    a0 = 1.0 + al;
    return pack_coeffs(to_q18((1.0 + cs) / 2.0 / a0), to_q18(-2.0 * cs / a0),
                       to_q18((1.0 - al) / a0));
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CFG_DATA_BITS-1:0];
  endfunction

  // coefficient within about +-0.5
  function automatic logic [COEFF_BITS-1:0] rand_small_coeff();
    int v;
    v = $urandom_range(0, 262144);
    v = v - 131072;
    return v[COEFF_BITS-1:0];
  endfunction

  // samples: full scale, small enough to meet the gate, moderate, and uniform noise
  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int          v;
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0: return FULL_POS;
      1: return FULL_NEG;
      2, 3: begin
        v = $urandom_range(0, 4000);
        v = v - 2000;
        return v[SAMPLE_BITS-1:0];
      end
      4: begin
        v = $urandom_range(0, 400000);
        v = v - 200000;
        return v[SAMPLE_BITS-1:0];
      end
      default: begin
        r = $urandom;
        return r[SAMPLE_BITS-1:0];
      end
    endcase
  endfunction

  // sender idle cycles before an item
  function automatic int rand_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    if (pick < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
    write_idx_q.push_back(idx);
    write_data_q.push_back(data);
  endtask

  // 8th-order butterworth high-pass split into four sections
  task automatic queue_butterworth(input real fc);
    queue_write(REG_COEF1, hp_section(fc, 0.5097955791041592));
    queue_write(REG_COEF2, hp_section(fc, 0.6013448869350453));
    queue_write(REG_COEF3, hp_section(fc, 0.8999762231364156));
    queue_write(REG_COEF4, hp_section(fc, 2.5629154477415055));
  endtask

  // issue the queued writes on consecutive edges
  task automatic apply_writes();
    while (write_idx_q.size() > 0) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= write_idx_q.pop_front();
      cfg_wdata <= write_data_q.pop_front();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // stop sending and wait until every owed result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // offer one item after gap idle cycles and wait for it to be taken
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic first,
                             input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= {s, first};
    do @(posedge clk); while (!in_ready);
  endtask

  // stimulus
  initial begin
    int   phase;
    int   n;
    int   k;
    int   blk_len;
    logic first;
    logic burst;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bypass straight out of reset
    push_sample(FULL_POS, 1'b0, 0);
    push_sample(FULL_NEG, 1'b1, 0);
    push_sample('0, 1'b0, 0);
    push_sample(-1, 1'b0, 1);

    // impulse response of a real filter, no gate
    settle();
    queue_write(REG_ENABLE, 63'h5A5A_0000_0000_0001);
    queue_butterworth(0.02);
    queue_write(REG_THRESH, '0);
    apply_writes();
    push_sample(FULL_POS, 1'b1, 0);
    push_sample('0, 1'b0, 0);
    push_sample('0, 1'b0, 0);
    push_sample('0, 1'b0, 0);
    push_sample(FULL_NEG, 1'b0, 0);
    push_sample(24'sd1, 1'b0, 0);
    push_sample(-1, 1'b0, 0);
    push_sample('0, 1'b1, 0);

    // extreme coefficients drive saturation, threshold at full scale
    settle();
    queue_write(REG_COEF1, pack_coeffs(C_MAX, C_MIN, C_MIN));
    queue_write(REG_COEF2, ALL_ONES);
    queue_write(REG_COEF3, pack_coeffs(C_MIN, C_MAX, C_MAX));
    queue_write(REG_COEF4, pack_coeffs(C_MAX, '0, '0));
    queue_write(REG_THRESH, 63'd8388608);
    queue_write(REG_SPARE_LO, ALL_ONES);
    queue_write(REG_SPARE_HI, rand63());
    apply_writes();
    push_sample(FULL_POS, 1'b1, 0);
    push_sample(FULL_NEG, 1'b0, 0);
    push_sample(FULL_NEG, 1'b1, 0);
    push_sample('0, 1'b0, 0);
    push_sample(24'sh123456, 1'b0, 0);

    // all-ones threshold field gates everything
    settle();
    queue_write(REG_THRESH, ALL_ONES);
    apply_writes();
    push_sample(FULL_POS, 1'b1, 0);
    push_sample(FULL_NEG, 1'b0, 0);

    // disabled with junk in the upper bits: delays must hold across it
    settle();
    queue_write(REG_ENABLE, ALL_ONES - 63'd1);
    apply_writes();
    push_sample(24'sh400000, 1'b0, 0);
    push_sample(-5, 1'b0, 0);
    settle();
    queue_write(REG_ENABLE, 63'd1);
    queue_write(REG_THRESH, '0);
    apply_writes();
    push_sample(24'sh200000, 1'b0, 0);
    push_sample(-7, 1'b0, 0);

    // zero coefficients give zero with no gate
    settle();
    queue_write(REG_COEF1, '0);
    queue_write(REG_COEF2, '0);
    queue_write(REG_COEF3, '0);
    queue_write(REG_COEF4, '0);
    apply_writes();
    push_sample(FULL_POS, 1'b0, 0);
    push_sample(FULL_NEG, 1'b0, 0);

    // random phases, each under its own configuration
    for (phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: begin
          queue_write(REG_ENABLE, rand63() & ~63'd1);
          queue_write(REG_COEF1, rand63());
          queue_write(REG_COEF2, rand63());
          queue_write(REG_COEF3, rand63());
          queue_write(REG_COEF4, rand63());
          queue_write(REG_THRESH, rand63());
        end
        1: begin
          queue_write(REG_ENABLE, 63'd1);
          queue_butterworth(0.01);
          queue_write(REG_THRESH, '0);
        end
        2: begin
          queue_write(REG_ENABLE, 63'd1);
          queue_butterworth(real'($urandom_range(1, 450)) / 1000.0);
          queue_write(REG_THRESH, 63'($urandom_range(0, 4096)));
        end
        3: begin
          queue_write(REG_ENABLE, 63'd1);
          queue_write(REG_COEF1, rand63());
          queue_write(REG_COEF2, rand63());
          queue_write(REG_COEF3, rand63());
          queue_write(REG_COEF4, rand63());
          queue_write(REG_THRESH, 63'($urandom_range(0, 8388608)));
        end
        4: begin
          queue_write(REG_ENABLE, 63'd1);
          queue_write(REG_COEF1, ALL_ONES);
          queue_write(REG_COEF2, pack_coeffs(C_MAX, C_MIN, C_MAX));
          queue_write(REG_COEF3, pack_coeffs(C_MIN, C_MIN, C_MIN));
          queue_write(REG_COEF4, pack_coeffs(C_MAX, C_MAX, C_MAX));
          queue_write(REG_THRESH, 63'd8388608);
        end
        5: begin
          queue_write(REG_ENABLE, 63'd1);
          queue_write(REG_COEF1, pack_coeffs(rand_small_coeff(), rand_small_coeff(),
                                             rand_small_coeff()));
          queue_write(REG_COEF2, pack_coeffs(rand_small_coeff(), rand_small_coeff(),
                                             rand_small_coeff()));
          queue_write(REG_COEF3, pack_coeffs(rand_small_coeff(), rand_small_coeff(),
                                             rand_small_coeff()));
          queue_write(REG_COEF4, pack_coeffs(rand_small_coeff(), rand_small_coeff(),
                                             rand_small_coeff()));
          queue_write(REG_THRESH, 63'($urandom_range(0, 255)));
        end
        6: begin
          queue_write(REG_ENABLE, 63'd1);
          queue_butterworth(0.05);
          queue_write(REG_THRESH, rand63() | 63'hFF_FFFF);
          queue_write(REG_SPARE_LO, rand63());
          queue_write(REG_SPARE_HI, rand63());
        end
        default: begin
          queue_write(REG_ENABLE, rand63() | 63'd1);
          queue_butterworth(0.2);
          queue_write(REG_THRESH, 63'd100);
        end
      endcase
      apply_writes();

      // blocks that mostly open with a clear, some sent back to back
      n = 0;
      while (n < 190) begin
        blk_len = $urandom_range(1, 40);
        burst   = ($urandom_range(0, 3) == 0);
        for (k = 0; k < blk_len && n < 190; k++) begin
          if (k == 0) first = ($urandom_range(0, 4) != 0);
          else first = ($urandom_range(0, 49) == 0);
          push_sample(rand_sample(), first, burst ? 0 : rand_gap());
          n++;
        end
      end
    end

    // drain and give the verdict
    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
